### rtl/mps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mps_pkg
// shared constants, operation and status codes, and the control and status
// structs that pass between the sequencer controller and its datapath
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int DEF_NUM_SLOTS   = 8;
    localparam int DEF_MAX_PATTERN = 32;

    localparam int PATTERN_W = 32;
    localparam int POS_W     = 5;
    localparam int LEN_W     = 6;
    localparam int PERIOD_W  = 16;
    localparam int REPS_W    = 16;
    localparam int TIME_W    = 32;
    localparam int MODE_W    = 3;
    localparam int SLOT_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int MASK_W    = 8;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_TICK          = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEFINE        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_START_FOREVER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_START_COUNTED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOP          = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR         = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALL     = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SET   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DEFINED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDEFINED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_REPS = 3'd4;

    typedef struct packed {
        logic latch;
        logic exec;
        logic step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic scan_last;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/mps_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mps_datapath
// per-slot state registers, operation decode and the one-slot-per-cycle
// step unit used during a tick scan, plus the result register
// ----------------------------------------------------------------------------
module mps_datapath #(
    parameter int NUM_SLOTS   = mps_pkg::DEF_NUM_SLOTS,
    parameter int MAX_PATTERN = mps_pkg::DEF_MAX_PATTERN
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire mps_pkg::t_dp_cmd            i_cmd,
    output mps_pkg::t_dp_status              o_status,
    input  wire [mps_pkg::IN_TDATA_W-1:0]    i_in_data,
    output logic [mps_pkg::OUT_TDATA_W-1:0]  o_out_data
);
    import mps_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);
    localparam int LEN_LIMIT = (MAX_PATTERN < PATTERN_W) ? MAX_PATTERN : PATTERN_W;
    localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(LEN_LIMIT);

    logic [MODE_W-1:0]    r_mode;
    logic [SLOT_W-1:0]    r_slot;
    logic [TIME_W-1:0]    r_now;
    logic [PATTERN_W-1:0] r_bits;
    logic [LEN_W-1:0]     r_len;
    logic [PERIOD_W-1:0]  r_per;
    logic [REPS_W-1:0]    r_reps;
    logic [IW-1:0]        r_scan;
    logic [MASK_W-1:0]    r_mask;
    logic [STATUS_W-1:0]  r_status;

    logic                 r_def    [NUM_SLOTS];
    logic                 r_en     [NUM_SLOTS];
    logic                 r_fev    [NUM_SLOTS];
    logic [PATTERN_W-1:0] r_pat    [NUM_SLOTS];
    logic [LEN_W-1:0]     r_plen   [NUM_SLOTS];
    logic [PERIOD_W-1:0]  r_period [NUM_SLOTS];
    logic [POS_W-1:0]     r_pos    [NUM_SLOTS];
    logic [REPS_W-1:0]    r_passes [NUM_SLOTS];
    logic [TIME_W-1:0]    r_last   [NUM_SLOTS];

    logic [7:0]          slot_ext;
    logic [7:0]          scan_ext;
    logic                in_range;
    logic [IW-1:0]       addr;
    logic [TIME_W-1:0]   elapsed;
    logic [LEN_W-1:0]    pos_inc;
    logic                due;
    logic                fires;
    logic                wrap;
    logic                len_bad;
    logic                slot_ok;
    logic [STATUS_W-1:0] ex_status;
    logic                wr_define;
    logic                wr_start_f;
    logic                wr_start_c;
    logic                wr_stop;
    logic                wr_clear;
    logic                wr_clear_all;

    assign slot_ext = {5'd0, r_slot};
    assign scan_ext = 8'(r_scan);
    assign in_range = slot_ext < 8'(NUM_SLOTS);
    assign addr     = i_cmd.step ? r_scan : slot_ext[IW-1:0];
    assign slot_ok  = in_range && r_def[addr];

    assign elapsed = r_now - r_last[addr];
    assign due     = r_def[addr] && r_en[addr] && (elapsed >= {16'd0, r_period[addr]});
    assign fires   = r_pat[addr][r_pos[addr]];
    assign pos_inc = {1'b0, r_pos[addr]} + 6'd1;
    assign wrap    = pos_inc >= r_plen[addr];
    assign len_bad = (r_len == '0) || ({1'b0, r_len} > MAX_LEN);

    always_comb begin
        ex_status    = ST_OK;
        wr_define    = 1'b0;
        wr_start_f   = 1'b0;
        wr_start_c   = 1'b0;
        wr_stop      = 1'b0;
        wr_clear     = 1'b0;
        wr_clear_all = 1'b0;
        unique case (r_mode)
            MODE_TICK: begin
                ex_status = ST_OK;
            end
            MODE_DEFINE: begin
                if (!in_range) begin
                    ex_status = ST_BAD_SET;
                end else if (r_def[addr]) begin
                    ex_status = ST_DEFINED;
                end else if ((r_per == '0) || len_bad) begin
                    ex_status = ST_BAD_SET;
                end else begin
                    wr_define = i_cmd.exec;
                end
            end
            MODE_START_FOREVER: begin
                if (!slot_ok) ex_status = ST_UNDEFINED;
                else wr_start_f = i_cmd.exec;
            end
            MODE_START_COUNTED: begin
                if (r_reps == '0) ex_status = ST_ZERO_REPS;
                else if (!slot_ok) ex_status = ST_UNDEFINED;
                else wr_start_c = i_cmd.exec;
            end
            MODE_STOP: begin
                if (!slot_ok) ex_status = ST_UNDEFINED;
                else wr_stop = i_cmd.exec;
            end
            MODE_CLEAR: begin
                if (!slot_ok) ex_status = ST_UNDEFINED;
                else wr_clear = i_cmd.exec;
            end
            MODE_CLEAR_ALL: begin
                wr_clear_all = i_cmd.exec;
            end
            default: begin
                ex_status = ST_BAD_SET;
            end
        endcase
    end

    // item registers and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_in_data[2:0];
            r_slot <= i_in_data[5:3];
            r_now  <= i_in_data[37:6];
            r_bits <= i_in_data[69:38];
            r_len  <= i_in_data[75:70];
            r_per  <= i_in_data[91:76];
            r_reps <= i_in_data[107:92];
        end
        if (i_cmd.latch) begin
            r_scan   <= '0;
            r_mask   <= '0;
            r_status <= ST_OK;
        end else begin
            if (i_cmd.exec) r_status <= ex_status;
            if (i_cmd.step) begin
                r_scan <= r_scan + IW'(1);
                if (due && fires && (scan_ext < 8'd8)) r_mask[scan_ext[2:0]] <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            o_out_data <= {(OUT_TDATA_W - STATUS_W - MASK_W)'(0), r_status, r_mask};
        end
    end

    // slot control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_def[i]  <= 1'b0;
                r_en[i]   <= 1'b0;
                r_last[i] <= '0;
            end
        end else if (wr_clear_all) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_def[i]  <= 1'b0;
                r_en[i]   <= 1'b0;
                r_last[i] <= '0;
            end
        end else if (wr_clear) begin
            r_def[addr]  <= 1'b0;
            r_en[addr]   <= 1'b0;
            r_last[addr] <= '0;
        end else if (wr_define) begin
            r_def[addr] <= 1'b1;
            r_en[addr]  <= 1'b0;
        end else if (wr_start_f || wr_start_c) begin
            r_en[addr] <= 1'b1;
        end else if (wr_stop) begin
            r_en[addr] <= 1'b0;
        end else if (i_cmd.step && due) begin
            r_last[addr] <= r_now;
            if (wrap && !r_fev[addr] && (r_passes[addr] <= 16'd1)) r_en[addr] <= 1'b0;
        end
    end

    // slot settings and progress
    always_ff @(posedge i_clk) begin
        if (wr_define) begin
            r_pat[addr]    <= r_bits;
            r_plen[addr]   <= r_len;
            r_period[addr] <= r_per;
            r_pos[addr]    <= '0;
            r_fev[addr]    <= 1'b0;
        end else if (wr_start_f) begin
            r_fev[addr] <= 1'b1;
        end else if (wr_start_c) begin
            r_fev[addr]    <= 1'b0;
            r_passes[addr] <= r_reps;
        end else if (i_cmd.step && due) begin
            r_pos[addr] <= wrap ? '0 : pos_inc[POS_W-1:0];
            if (wrap && !r_fev[addr]) begin
                if (r_passes[addr] <= 16'd1) r_passes[addr] <= '0;
                else r_passes[addr] <= r_passes[addr] - 16'd1;
            end
        end
    end

    assign o_status.is_tick   = (r_mode == MODE_TICK);
    assign o_status.scan_last = (r_scan == LAST_IDX);

endmodule

`default_nettype wire

### rtl/mps_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mps_ctrl
// sequencer controller: accepts a beat, runs the execute step or a tick
// scan over all slots, then hands the result to the output register
// ----------------------------------------------------------------------------
module mps_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output mps_pkg::t_dp_cmd     o_cmd,
    input  wire mps_pkg::t_dp_status i_status
);
    import mps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !o_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd.latch    = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.is_tick) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.scan_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over an unread beat");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_status.scan_last) |=> (r_state == S_DONE))
        else $error("tick scan did not finish at the last slot");

    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_out_valid)
        else $error("result beat not presented");

endmodule

`default_nettype wire

### rtl/multi_slot_pattern_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_pattern_sequencer_core
// pattern sequencer with NUM_SLOTS independent step patterns
//
// one command beat on the s_axis channel gives exactly one result beat on
// the m_axis channel. a command beat is taken when the block is idle; the
// result sits in an output register, so the next command is taken while an
// earlier result still waits on a stalled receiver.
// define, start, stop and clear pass from the accept state through the execute
// state to the result state; a tick runs a scan after the execute state, in
// which the step unit visits one slot per cycle. a new command is taken only
// once the last result is loaded into the output register and the block is idle.
// a stalled receiver holds the result beat and, once the next result is
// done, holds the block in its result state until the beat is taken.
// reset clears all slots to undefined and stopped with zero time stamps,
// drops m_axis_tvalid and leaves the block ready.
// ----------------------------------------------------------------------------
module multi_slot_pattern_sequencer_core #(
    parameter int NUM_SLOTS   = mps_pkg::DEF_NUM_SLOTS,
    parameter int MAX_PATTERN = mps_pkg::DEF_MAX_PATTERN
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // mode, slot, now_ms, pattern_bits, pattern_length, step_ms, repeat_count
    input  wire [mps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // fire_mask, status
    output logic [mps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import mps_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    mps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    mps_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_in_data  (s_axis_tdata),
        .o_out_data (m_axis_tdata)
    );

endmodule

`default_nettype wire
